FILE: src/i2cms_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
// Used by the front, queue and phase sequencer modules; no dependencies.
`default_nettype none

package i2cms_pkg;

   typedef enum logic [2:0] {
      KIND_START = 3'd0,
      KIND_STOP  = 3'd1,
      KIND_WRITE = 3'd2,
      KIND_READ  = 3'd3,
      KIND_ACK   = 3'd4,
      KIND_NACK  = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] write_byte;
      logic [7:0] read_levels;
   } cmd_type;

   localparam logic [15:0] PHASE_CYCLES_RESET = 16'd100;
   localparam int          CMD_QUEUE_DEPTH    = 2;
   localparam logic [4:0]  STEP_LAST_SHORT2   = 5'd1;
   localparam logic [4:0]  STEP_LAST_SHORT3   = 5'd2;
   localparam logic [4:0]  STEP_LAST_SHORT4   = 5'd3;
   localparam logic [4:0]  STEP_LAST_BYTE     = 5'd16;

endpackage

`default_nettype wire

FILE: src/i2cms_front.sv
// Front end: accepts command items and drops codes that name no command.
// Depends on i2cms_pkg; feeds the command queue.
`default_nettype none

module i2cms_front (
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_kind,
   input  wire logic [7:0]         req_write_byte,
   input  wire logic [7:0]         req_read_levels,
   output logic                    push,
   output i2cms_pkg::cmd_type      push_cmd,
   input  wire logic               queue_full
);
   import i2cms_pkg::*;

   logic known;

   always_comb begin
      case (kind_type'(req_kind))
         KIND_START, KIND_STOP, KIND_WRITE, KIND_READ, KIND_ACK, KIND_NACK: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   assign req_ready            = !queue_full;
   assign push                 = req_valid && !queue_full && known;
   assign push_cmd.kind        = kind_type'(req_kind);
   assign push_cmd.write_byte  = req_write_byte;
   assign push_cmd.read_levels = req_read_levels;

endmodule

`default_nettype wire

FILE: src/i2cms_cmd_fifo.sv
// Short command queue between the front end and the phase sequencer.
// Depends on i2cms_pkg for the command type.
`default_nettype none

module i2cms_cmd_fifo #(
   parameter int DEPTH = i2cms_pkg::CMD_QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire i2cms_pkg::cmd_type push_cmd,
   output logic                    full,
   input  wire logic               pop,
   output logic                    not_empty,
   output i2cms_pkg::cmd_type      pop_cmd
);
   import i2cms_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_MAX);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_MAX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: src/i2cms_phase_seq.sv
// Back end: steps through the pin phases of each command and holds each phase.
// Depends on i2cms_pkg; takes commands from the command queue.
`default_nettype none

module i2cms_phase_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [15:0]        csr_wr_data,
   input  wire logic               cmd_valid,
   input  wire i2cms_pkg::cmd_type cmd,
   output logic                    cmd_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_scl,
   output logic                    rsp_sda,
   output logic [7:0]              rsp_read_byte,
   output logic                    rsp_last
);
   import i2cms_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [4:0]  step_ff, step_in;
   logic        scl_ff, sda_ff;
   logic [15:0] hold_ff, hold_in;
   logic [15:0] phase_cycles_ff;
   logic        rsp_valid_ff;
   logic        ph_scl, ph_sda, ph_last;
   logic [7:0]  ph_rbyte;
   logic [2:0]  bit_idx;
   logic        issue;

   assign bit_idx = 3'd7 - step_ff[3:1];

   always_comb begin
      ph_scl   = 1'b0;
      ph_sda   = 1'b1;
      ph_last  = 1'b0;
      ph_rbyte = 8'd0;
      case (cmd_ff.kind)
         KIND_START: begin
            ph_scl  = (step_ff == 5'd1) || (step_ff == 5'd2);
            ph_sda  = (step_ff == 5'd0) || (step_ff == 5'd1);
            ph_last = (step_ff == STEP_LAST_SHORT4);
         end
         KIND_STOP: begin
            ph_scl  = step_ff[1];
            ph_sda  = (step_ff == 5'd0) ? sda_ff : (step_ff == 5'd3);
            ph_last = (step_ff == STEP_LAST_SHORT4);
         end
         KIND_WRITE: begin
            if (step_ff == STEP_LAST_BYTE) begin
               ph_scl  = 1'b0;
               ph_sda  = 1'b1;
               ph_last = 1'b1;
            end else begin
               ph_sda = cmd_ff.write_byte[bit_idx];
               if (step_ff[0]) begin
                  ph_scl = 1'b1;
               end else begin
                  ph_scl = (step_ff == 5'd0) ? scl_ff : 1'b0;
               end
            end
         end
         KIND_READ: begin
            ph_sda = 1'b1;
            if (step_ff == 5'd0) begin
               ph_scl = scl_ff;
            end else begin
               ph_scl = step_ff[0];
            end
            ph_last = (step_ff == STEP_LAST_BYTE);
            if (ph_last) begin
               ph_rbyte = cmd_ff.read_levels;
            end
         end
         KIND_ACK: begin
            ph_scl  = (step_ff == 5'd0) ? scl_ff : (step_ff == 5'd1);
            ph_sda  = (step_ff == 5'd2);
            ph_last = (step_ff == STEP_LAST_SHORT3);
         end
         KIND_NACK: begin
            ph_scl  = (step_ff == 5'd0) ? scl_ff : 1'b1;
            ph_sda  = 1'b1;
            ph_last = (step_ff == STEP_LAST_SHORT2);
         end
         default: begin
            ph_last = 1'b1;
         end
      endcase
   end

   assign issue   = (state_ff == ST_RUN) && (hold_ff == '0) && (!rsp_valid_ff || rsp_ready);
   assign cmd_pop = cmd_valid && ((state_ff == ST_IDLE) || (issue && ph_last));

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      step_in  = step_ff;
      hold_in  = hold_ff;
      if (issue) begin
         hold_in = (phase_cycles_ff == '0) ? '0 : phase_cycles_ff - 1'b1;
         step_in = step_ff + 1'b1;
         if (ph_last) begin
            state_in = ST_IDLE;
         end
      end else if (hold_ff != '0) begin
         hold_in = hold_ff - 1'b1;
      end
      if (cmd_pop) begin
         state_in = ST_RUN;
         cmd_in   = cmd;
         step_in  = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= 5'd0;
         hold_ff         <= '0;
         scl_ff          <= 1'b1;
         sda_ff          <= 1'b1;
         phase_cycles_ff <= PHASE_CYCLES_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         hold_ff  <= hold_in;
         if (csr_wr_en) begin
            phase_cycles_ff <= csr_wr_data;
         end
         if (issue) begin
            scl_ff       <= ph_scl;
            sda_ff       <= ph_sda;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (issue) begin
         rsp_scl       <= ph_scl;
         rsp_sda       <= ph_sda;
         rsp_read_byte <= ph_rbyte;
         rsp_last      <= ph_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: src/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer.
// Depends on i2cms_pkg, i2cms_front, i2cms_cmd_fifo and i2cms_phase_seq.
//
// Each req_ item is one bus command (start, stop, write, read, ack, nack).
// The block answers with one rsp_ item per pin phase, giving the SCL and SDA
// levels; rsp_last marks the final phase of a command, and a read returns
// its byte in rsp_read_byte on that phase. Codes that name no command are
// accepted and produce no items.
// Each phase is held by the hold counter in the phase sequencer, which is
// loaded from phase_cycles (csr_wr_data, written with csr_wr_en; zero acts
// as one). A command has 4 phases for start and stop, 17 for write and read,
// 3 for ack and 2 for nack.
// A command queue lets req_ items be accepted while earlier commands are
// still being driven, and a stalled rsp_ channel only stops the sequencer.
// Reset empties the queue, releases both lines high and sets phase_cycles
// to 100.
`default_nettype none

module i2c_master_bit_sequencer #(
   parameter int CMD_QUEUE_DEPTH = i2cms_pkg::CMD_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_write_byte,
   input  wire logic [7:0]  req_read_levels,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_scl,
   output logic             rsp_sda,
   output logic [7:0]       rsp_read_byte,
   output logic             rsp_last
);
   import i2cms_pkg::*;

   logic    push, queue_full, pop, queue_not_empty;
   cmd_type push_cmd, pop_cmd;

   i2cms_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_write_byte  (req_write_byte),
      .req_read_levels (req_read_levels),
      .push            (push),
      .push_cmd        (push_cmd),
      .queue_full      (queue_full)
   );

   i2cms_cmd_fifo #(
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_cmd   (pop_cmd)
   );

   i2cms_phase_seq u_phase_seq (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .cmd_valid     (queue_not_empty),
      .cmd           (pop_cmd),
      .cmd_pop       (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_scl       (rsp_scl),
      .rsp_sda       (rsp_sda),
      .rsp_read_byte (rsp_read_byte),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

FILE: src/i2cms_checker.sv
// Port-level checks for the I2C master bit sequencer, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module i2cms_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_scl,
   input wire logic       rsp_sda,
   input wire logic [7:0] rsp_read_byte,
   input wire logic       rsp_last
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scl) && $stable(rsp_sda)
         && $stable(rsp_read_byte) && $stable(rsp_last))
      else $error("stalled result item changed");

   a_byte_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_read_byte == 8'd0)
      else $error("read byte shown before the last phase");

   a_last_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_scl |-> rsp_sda)
      else $error("command ended with SCL high and SDA low");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_scl       (rsp_scl),
   .rsp_sda       (rsp_sda),
   .rsp_read_byte (rsp_read_byte),
   .rsp_last      (rsp_last)
);

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the I2C master bit sequencer (i2c_master_bit_sequencer).
// It drives bus commands and checks every SCL/SDA pin phase against a local predictor.
// Depends on i2cms_pkg and the sequencer RTL; it reads no files.
module tb;
   import i2cms_pkg::*;

   localparam logic [2:0] KIND_RESERVED_A = 3'd6;
   localparam logic [2:0] KIND_RESERVED_B = 3'd7;
   localparam int WATCHDOG_LIMIT = 300000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] write_byte;
      logic [7:0] read_levels;
   } command_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic [7:0] read_byte;
      logic       last;
   } pin_phase_type;

   typedef struct packed {
      command_type cmd;
      logic        typed;
      logic [4:0]  count;
      logic [33:0] pins;
      logic [7:0]  read_byte;
   } bus_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = 3'd0;
   logic [7:0]  req_write_byte = 8'd0;
   logic [7:0]  req_read_levels = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_scl;
   logic        rsp_sda;
   logic [7:0]  rsp_read_byte;
   logic        rsp_last;

   pin_phase_type expected_phases[$];
   bus_row_type   directed_rows[$];
   logic       bus_scl = 1'b1;
   logic       bus_sda = 1'b1;
   int         error_count = 0;
   int         req_idle_pct = 0;
   int         rsp_stall_pct = 0;
   int         stall_cycles = 0;
   logic [15:0] hold_setting = PHASE_CYCLES_RESET;

   i2c_master_bit_sequencer dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_write_byte(req_write_byte),
      .req_read_levels(req_read_levels),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_scl(rsp_scl),
      .rsp_sda(rsp_sda),
      .rsp_read_byte(rsp_read_byte),
      .rsp_last(rsp_last)
   );

   always #6 clock = ~clock;

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   function automatic void add_phase(input logic scl, input logic sda,
                                     input logic [7:0] rbyte, input logic lst);
      pin_phase_type p;
      p.scl = scl;
      p.sda = sda;
      p.read_byte = rbyte;
      p.last = lst;
      expected_phases.push_back(p);
      bus_scl = scl;
      bus_sda = sda;
   endfunction

   // Appends the pin phases of one command and returns how many there are.
   function automatic int predict_pin_phases(input command_type c);
      int start_size;
      logic low_level;
      logic [7:0] shifter;
      start_size = expected_phases.size();
      case (c.kind)
         KIND_START: begin
            add_phase(1'b0, 1'b1, 8'd0, 1'b0);
            add_phase(1'b1, 1'b1, 8'd0, 1'b0);
            add_phase(1'b1, 1'b0, 8'd0, 1'b0);
            add_phase(1'b0, 1'b0, 8'd0, 1'b1);
         end
         KIND_STOP: begin
            add_phase(1'b0, bus_sda, 8'd0, 1'b0);
            add_phase(1'b0, 1'b0, 8'd0, 1'b0);
            add_phase(1'b1, 1'b0, 8'd0, 1'b0);
            add_phase(1'b1, 1'b1, 8'd0, 1'b1);
         end
         KIND_WRITE: begin
            shifter = c.write_byte;
            low_level = bus_scl;
            for (int i = 0; i < 8; i++) begin
               add_phase(low_level, shifter[7], 8'd0, 1'b0);
               add_phase(1'b1, shifter[7], 8'd0, 1'b0);
               shifter = {shifter[6:0], 1'b0};
               low_level = 1'b0;
            end
            add_phase(1'b0, 1'b1, 8'd0, 1'b1);
         end
         KIND_READ: begin
            shifter = 8'd0;
            add_phase(bus_scl, 1'b1, 8'd0, 1'b0);
            for (int i = 0; i < 8; i++) begin
               add_phase(1'b1, 1'b1, 8'd0, 1'b0);
               shifter = {shifter[6:0], c.read_levels[7 - i]};
               if (i == 7) add_phase(1'b0, 1'b1, shifter, 1'b1);
               else add_phase(1'b0, 1'b1, 8'd0, 1'b0);
            end
         end
         KIND_ACK: begin
            add_phase(bus_scl, 1'b0, 8'd0, 1'b0);
            add_phase(1'b1, 1'b0, 8'd0, 1'b0);
            add_phase(1'b0, 1'b1, 8'd0, 1'b1);
         end
         KIND_NACK: begin
            add_phase(bus_scl, 1'b1, 8'd0, 1'b0);
            add_phase(1'b1, 1'b1, 8'd0, 1'b1);
         end
         default: begin
         end
      endcase
      return expected_phases.size() - start_size;
   endfunction

   function automatic command_type random_command(input logic [2:0] kind);
      command_type c;
      c.kind = kind;
      c.write_byte = 8'($urandom_range(0, 255));
      c.read_levels = 8'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic add_row(input logic [2:0] kind, input logic [7:0] wbyte,
                          input logic [7:0] levels, input logic typed,
                          input logic [4:0] count, input logic [33:0] pins,
                          input logic [7:0] rbyte);
      bus_row_type r;
      r.cmd.kind = kind;
      r.cmd.write_byte = wbyte;
      r.cmd.read_levels = levels;
      r.typed = typed;
      r.count = count;
      r.pins = pins;
      r.read_byte = rbyte;
      directed_rows.push_back(r);
   endtask

   task automatic send_command(input command_type c, output int n_phases);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_kind <= c.kind;
      req_write_byte <= c.write_byte;
      req_read_levels <= c.read_levels;
      do @(posedge clock); while (!req_ready);
      n_phases = predict_pin_phases(c);
   endtask

   // Waits until the block has gone quiet, then lets the last hold run out.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (expected_phases.size() != 0) @(posedge clock);
      repeat (int'(hold_setting) + 16) @(posedge clock);
   endtask

   task automatic set_phase_cycles(input logic [15:0] value);
      wait_for_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      hold_setting = value;
   endtask

   // Mostly well-formed transfers with random content, plus some noise.
   task automatic run_random(input int target);
      command_type burst[$];
      logic [7:0] address;
      int n_sent;
      int n_bytes;
      int n;
      n_sent = 0;
      while (n_sent < target) begin
         burst.delete();
         if ($urandom_range(0, 9) < 8) begin
            address = 8'($urandom_range(0, 255));
            burst.push_back(random_command(KIND_START));
            burst.push_back(random_command(KIND_WRITE));
            burst[1].write_byte = address;
            n_bytes = $urandom_range(1, 3);
            for (int i = 0; i < n_bytes; i++) begin
               if (address[0]) begin
                  burst.push_back(random_command(KIND_READ));
                  burst.push_back(random_command((i == n_bytes - 1) ? KIND_NACK : KIND_ACK));
               end else begin
                  burst.push_back(random_command(KIND_WRITE));
               end
            end
            if ($urandom_range(0, 3) == 0) burst.push_back(random_command(KIND_START));
            burst.push_back(random_command(KIND_STOP));
         end else begin
            n_bytes = $urandom_range(1, 3);
            for (int i = 0; i < n_bytes; i++) begin
               burst.push_back(random_command(3'($urandom_range(0, 7))));
            end
         end
         foreach (burst[j]) begin
            send_command(burst[j], n);
            if (burst[j].kind != KIND_RESERVED_A && burst[j].kind != KIND_RESERVED_B) begin
               n_sent++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : check_phases
      pin_phase_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_phases.size() == 0) begin
            flag_error($sformatf("unexpected item scl=%b sda=%b read_byte=%02h last=%b",
                                 rsp_scl, rsp_sda, rsp_read_byte, rsp_last));
         end else begin
            want = expected_phases.pop_front();
            if (want.scl !== rsp_scl || want.sda !== rsp_sda ||
                want.read_byte !== rsp_read_byte || want.last !== rsp_last) begin
               flag_error({$sformatf("expected scl=%b sda=%b read_byte=%02h last=%b",
                                     want.scl, want.sda, want.read_byte, want.last),
                           $sformatf(", got scl=%b sda=%b read_byte=%02h last=%b",
                                     rsp_scl, rsp_sda, rsp_read_byte, rsp_last)});
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      int n;
      int predicted;
      logic [4:0] k;
      logic [1:0] pair;
      pin_phase_type p;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(KIND_STOP, 8'hFF, 8'h00, 1'b1, 5'd4, 34'b01_00_10_11, 8'h00);
      add_row(KIND_START, 8'h00, 8'hFF, 1'b1, 5'd4, 34'b01_11_10_00, 8'h00);
      add_row(KIND_WRITE, 8'hFF, 8'h00, 1'b1, 5'd17, {{8{4'b0111}}, 2'b01}, 8'h00);
      add_row(KIND_ACK, 8'h00, 8'h00, 1'b1, 5'd3, 34'b00_10_01, 8'h00);
      add_row(KIND_WRITE, 8'h00, 8'hFF, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_NACK, 8'hFF, 8'hFF, 1'b1, 5'd2, 34'b01_11, 8'h00);
      add_row(KIND_READ, 8'h00, 8'hFF, 1'b1, 5'd17, {2'b11, {8{4'b1101}}}, 8'hFF);
      add_row(KIND_READ, 8'hFF, 8'h00, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_ACK, 8'hFF, 8'hFF, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_READ, 8'h00, 8'hA5, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_NACK, 8'h00, 8'h00, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_WRITE, 8'h5A, 8'h00, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_WRITE, 8'h80, 8'h7F, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_WRITE, 8'h01, 8'hFE, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_RESERVED_A, 8'hFF, 8'hFF, 1'b1, 5'd0, 34'd0, 8'h00);
      add_row(KIND_RESERVED_B, 8'h00, 8'h00, 1'b1, 5'd0, 34'd0, 8'h00);
      add_row(KIND_STOP, 8'h00, 8'h00, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_ACK, 8'h00, 8'h00, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_START, 8'hFF, 8'hFF, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_START, 8'h00, 8'h00, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_STOP, 8'hFF, 8'hFF, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_READ, 8'hFF, 8'h3C, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_READ, 8'h00, 8'h80, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_NACK, 8'hFF, 8'h01, 1'b0, 5'd0, 34'd0, 8'h00);
      add_row(KIND_STOP, 8'h00, 8'hFF, 1'b0, 5'd0, 34'd0, 8'h00);

      req_idle_pct = 36;
      rsp_stall_pct = 55;
      foreach (directed_rows[r]) begin
         send_command(directed_rows[r].cmd, predicted);
         if (directed_rows[r].typed) begin
            repeat (predicted) void'(expected_phases.pop_back());
            for (int i = 0; i < int'(directed_rows[r].count); i++) begin
               k = directed_rows[r].count - 5'd1 - 5'(i);
               pair = directed_rows[r].pins[2 * k +: 2];
               p.scl = pair[1];
               p.sda = pair[0];
               p.last = (k == 5'd0);
               p.read_byte = p.last ? directed_rows[r].read_byte : 8'h00;
               expected_phases.push_back(p);
            end
         end
      end

      set_phase_cycles(16'd1);
      run_random(65);

      set_phase_cycles(16'd0);
      req_idle_pct = 55;
      rsp_stall_pct = 36;
      run_random(65);

      set_phase_cycles(16'($urandom_range(2, 9)));
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random(65);

      set_phase_cycles(16'hFFFF);
      send_command(random_command(KIND_NACK), n);
      wait_for_idle();

      if (expected_phases.size() != 0) begin
         flag_error($sformatf("%0d expected items never arrived", expected_phases.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
